@@ rtl/shfr_pkg.sv @@
// Shared types, coefficient table and saturating arithmetic for the stereo halfband FIR.
package shfr_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int FRAC_W        = 15;
	localparam int TAP_COUNT     = 39;
	localparam int LANE_COUNT    = 8;
	localparam int TAPS_PER_LANE = (TAP_COUNT + LANE_COUNT - 1) / LANE_COUNT;
	localparam int CH_COUNT      = 2;
	localparam int PROD_W        = 2 * SAMPLE_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SAMPLE_W:0]   wide_t;
	typedef logic signed [PROD_W-1:0]   prod_t;

	localparam sample_t SAMPLE_MAX = 16'sh7fff;
	localparam sample_t SAMPLE_MIN = 16'sh8000;
	localparam prod_t   ROUND_HALF = prod_t'(1) <<< (FRAC_W - 1);

	// Downsample coefficients in Q15, oldest tap first.
	localparam sample_t DOWN_COEFS [TAP_COUNT] = '{
		-16'sd1,     16'sd0,  16'sd2,     16'sd0, -16'sd10,    16'sd0,  16'sd35,
		 16'sd0,    -16'sd103, 16'sd0,    16'sd266, 16'sd0,   -16'sd616, 16'sd0,
		 16'sd1332,  16'sd0, -16'sd2960,  16'sd0,  16'sd10246, 16'sd16384,
		 16'sd10246, 16'sd0, -16'sd2960,  16'sd0,  16'sd1332,  16'sd0,
		-16'sd616,   16'sd0,  16'sd266,   16'sd0, -16'sd103,   16'sd0,
		 16'sd35,    16'sd0, -16'sd10,    16'sd0,  16'sd2,     16'sd0,  -16'sd1
	};

	// Clamp a value one bit wider than a sample back into the sample range.
	function automatic sample_t clamp_wide(wide_t s);
		sample_t r;
		if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
			r = s[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
		end else begin
			r = s[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	function automatic sample_t sat_add(sample_t a, sample_t b);
		wide_t s;
		s = wide_t'(a) + wide_t'(b);
		return clamp_wide(s);
	endfunction

	// The upsample set is the downsample set doubled and clamped.
	function automatic sample_t coef_at(int k, logic up);
		wide_t d;
		d = wide_t'(DOWN_COEFS[k]) <<< 1;
		return up ? clamp_wide(d) : DOWN_COEFS[k];
	endfunction

	// Rounding Q15 multiply; the result always fits a sample for these coefficients.
	function automatic sample_t mul_q15(sample_t x, sample_t c);
		prod_t p;
		p = prod_t'(x) * prod_t'(c) + ROUND_HALF;
		return p[FRAC_W+SAMPLE_W-1:FRAC_W];
	endfunction

endpackage

@@ rtl/saturating_halfband_fir_resampler.sv @@
// Stereo 39-tap halfband FIR with Q15 coefficients and saturating 16-bit sums.
//
//  channel | handshake             | payload                          | direction
//  --------+-----------------------+----------------------------------+----------
//  cfg     | cfg_valid / cfg_ready | cfg_data (coefficient set)       | in
//  in      | in_valid / in_ready   | left_sample, right_sample, emit  | in
//  out     | out_valid / out_ready | left_out, right_out              | out
//
// One input word can be taken every clock cycle unless the output stalls. A word with
// emit set gives one output word, formed by the tap products, the lane sums, then
// the pairwise reduction into the output register. The three stages each
// hold their own valid bit, so bubbles are squeezed out and new words are taken
// while a finished result is still waiting on the output. Reset clears the delay
// lines to zero, selects the downsample coefficients and empties the pipeline.
// The configuration port is always ready.
module saturating_halfband_fir_resampler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  shfr_pkg::sample_t left_sample,
	input  shfr_pkg::sample_t right_sample,
	input  logic              emit,
	output logic              out_valid,
	input  logic              out_ready,
	output shfr_pkg::sample_t left_out,
	output shfr_pkg::sample_t right_out
);
	import shfr_pkg::*;

	// Channel 0 is left, channel 1 is right.
	localparam int CH_LEFT  = 0;
	localparam int CH_RIGHT = 1;

	logic    coef_set_q;

	// Delay lines: entry 0 is the oldest sample, the last entry the newest.
	sample_t line_q [CH_COUNT][TAP_COUNT];
	logic    pend_q;      // the line holds a word that asked for a result

	sample_t coef_c  [TAP_COUNT];
	sample_t prod_c  [CH_COUNT][TAP_COUNT];
	sample_t prod_s2 [CH_COUNT][TAP_COUNT];
	logic    valid_s2;

	sample_t lane_c  [CH_COUNT][LANE_COUNT];
	sample_t lane_s3 [CH_COUNT][LANE_COUNT];
	logic    valid_s3;

	sample_t red_c   [CH_COUNT][LANE_COUNT];
	sample_t res_q   [CH_COUNT];
	logic    out_valid_q;

	logic    en_out;
	logic    en_s3;
	logic    en_s2;
	logic    in_acc;

	// Each stage loads when it is empty or when its contents move on.
	assign en_out    = !out_valid_q || out_ready;
	assign en_s3     = !valid_s3 || en_out;
	assign en_s2     = !valid_s2 || en_s3;
	assign in_ready  = !pend_q || en_s2;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_set_q <= 1'b0;
		end else if (cfg_valid) begin
			coef_set_q <= cfg_data;
		end
	end

	// Shift the new pair in. When a pending word moves into the product stage
	// at the same edge, that stage has already sampled the old line contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CH_COUNT; c++) begin
				for (int k = 0; k < TAP_COUNT; k++) begin
					line_q[c][k] <= '0;
				end
			end
			pend_q <= 1'b0;
		end else begin
			if (in_acc) begin
				for (int c = 0; c < CH_COUNT; c++) begin
					for (int k = 0; k < TAP_COUNT - 1; k++) begin
						line_q[c][k] <= line_q[c][k+1];
					end
				end
				line_q[CH_LEFT][TAP_COUNT-1]  <= left_sample;
				line_q[CH_RIGHT][TAP_COUNT-1] <= right_sample;
				pend_q <= emit;
			end else if (en_s2) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Tap products; zero coefficients fold away in synthesis.
	always_comb begin
		for (int k = 0; k < TAP_COUNT; k++) begin
			coef_c[k] = coef_at(k, coef_set_q);
		end
		for (int c = 0; c < CH_COUNT; c++) begin
			for (int k = 0; k < TAP_COUNT; k++) begin
				prod_c[c][k] = mul_q15(line_q[c][k], coef_c[k]);
			end
		end
	end

	// Lane j accumulates taps j, j+8, ... in order, saturating after each add.
	always_comb begin
		for (int c = 0; c < CH_COUNT; c++) begin
			for (int j = 0; j < LANE_COUNT; j++) begin
				lane_c[c][j] = '0;
				for (int m = 0; m < TAPS_PER_LANE; m++) begin
					if (j + m * LANE_COUNT < TAP_COUNT) begin
						lane_c[c][j] = sat_add(lane_c[c][j], prod_s2[c][j + m * LANE_COUNT]);
					end
				end
			end
		end
	end

	// Pairwise reduction of the lanes in three saturating levels.
	always_comb begin
		for (int c = 0; c < CH_COUNT; c++) begin
			for (int j = 0; j < LANE_COUNT; j++) begin
				red_c[c][j] = lane_s3[c][j];
			end
			for (int n = LANE_COUNT >> 1; n >= 1; n = n >> 1) begin
				for (int j = 0; j < n; j++) begin
					red_c[c][j] = sat_add(red_c[c][2*j], red_c[c][2*j+1]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= pend_q;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && pend_q) begin
			prod_s2 <= prod_c;
		end
		if (en_s3 && valid_s2) begin
			lane_s3 <= lane_c;
		end
		if (en_out && valid_s3) begin
			for (int c = 0; c < CH_COUNT; c++) begin
				res_q[c] <= red_c[c][0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = res_q[CH_LEFT];
	assign right_out = res_q[CH_RIGHT];

endmodule
